>>> sv/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Command, status and controller state codes shared by the frequency count
// table and its testbench.
// ----------------------------------------------------------------------------
package fct_pkg;

  // Command codes carried on the input beat
  typedef enum logic [1:0] {
    CMD_COUNT  = 2'd0,
    CMD_REWIND = 2'd1,
    CMD_NEXT   = 2'd2
  } cmd_t;

  // Status codes carried on the result beat
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_PAST_END = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_t;

  localparam int OCC_W      = 32;
  localparam int KEY_PORT_W = 32;
  localparam int TOTAL_W    = 7;

endpackage

>>> sv/fct_ram.sv
// ----------------------------------------------------------------------------
// fct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/frequency_count_table.sv
// ----------------------------------------------------------------------------
// frequency_count_table
// Table of distinct keys in order of first arrival, each with a saturating
// occurrence count, plus a read cursor that walks the table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries in_cmd and in_key_in. Count
//   looks the key up and returns its new count (1 when appended, status
//   table full when no entry is free). Rewind sets the read cursor to the
//   first entry. Next returns the key and count under the cursor and
//   advances it, or status read past end.
//   Result channel (out_valid/out_ready) carries one beat per input beat,
//   with the distinct key total and whether the cursor still points at an
//   entry after that command.
//   Keys and counts live in one RAM row each; a count walks the stored rows
//   one read per cycle until the key matches or the last row is read; a next
//   reads its row in ST_READ, rewind and unused codes go straight to ST_RESP.
//   One command is processed at a time; a new beat is taken once the
//   previous result sits in the output register.
//   Reset empties the table and rewinds the cursor; no clearing pass runs.
//   When the receiver stalls, the finished result waits in the output
//   register and the controller holds until that register frees up.
// ----------------------------------------------------------------------------
module frequency_count_table #(
  parameter int ENTRIES = 64,
  parameter int KEY_W   = 32,
  parameter int COUNT_W = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [fct_pkg::KEY_PORT_W-1:0]    in_key_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fct_pkg::OCC_W-1:0]         out_occurrences,
  output logic [fct_pkg::KEY_PORT_W-1:0]    out_key_out,
  output logic [fct_pkg::TOTAL_W-1:0]       out_distinct_total,
  output logic                              out_more_left,
  output logic [1:0]                        out_status
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ROW_W = KEY_W + COUNT_W;
  localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(ENTRIES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  fct_pkg::state_t state_r, state_nxt;

  logic [1:0]            cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic [IDX_W-1:0]      idx_r;
  logic [CNT_W-1:0]      distinct_r;
  logic [CNT_W-1:0]      cursor_r;
  logic [COUNT_W-1:0]    res_occ_r;
  logic [KEY_W-1:0]      res_key_r;
  fct_pkg::status_t      res_stat_r;

  logic                            out_valid_r;
  logic [fct_pkg::OCC_W-1:0]       out_occ_r;
  logic [fct_pkg::KEY_PORT_W-1:0]  out_key_r;
  logic [fct_pkg::TOTAL_W-1:0]     out_total_r;
  logic                            out_more_r;
  logic [1:0]                      out_stat_r;

  logic                  in_fire;
  logic                  out_free;
  logic [KEY_W-1:0]      key_in_w;
  logic [63:0]           key_in_ext;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ROW_W-1:0]      wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [ROW_W-1:0]      rd_data;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_W-1:0]    rd_cnt;
  logic [COUNT_W-1:0]    sat_cnt;
  logic                  hit;
  logic                  last;
  logic                  full;
  logic [63:0]           occ_ext;
  logic [63:0]           key_ext;
  logic [15:0]           total_ext;

  // Storage for key and count rows
  fct_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode the row under scan
  assign key_in_ext = 64'(in_key_in);
  assign key_in_w   = key_in_ext[KEY_W-1:0];
  assign rd_key     = rd_data[KEY_W-1:0];
  assign rd_cnt     = rd_data[KEY_W +: COUNT_W];
  assign sat_cnt    = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_ONE;
  assign hit        = (rd_key == key_r);
  assign last       = ((CNT_W'(idx_r) + CNT_W'(1)) == distinct_r);
  assign full       = (distinct_r == FULL_CNT);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fct_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (in_cmd == fct_pkg::CMD_COUNT && distinct_r != '0) begin
            state_nxt = fct_pkg::ST_SCAN;
          end else if (in_cmd == fct_pkg::CMD_NEXT && cursor_r < distinct_r) begin
            state_nxt = fct_pkg::ST_READ;
          end else begin
            state_nxt = fct_pkg::ST_RESP;
          end
        end
      end
      fct_pkg::ST_SCAN: begin
        if (hit || last) begin
          state_nxt = fct_pkg::ST_RESP;
        end
      end
      fct_pkg::ST_READ: begin
        state_nxt = fct_pkg::ST_RESP;
      end
      fct_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = fct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fct_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory port controls
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = distinct_r[IDX_W-1:0];
    wr_data  = {COUNT_ONE, key_r};
    rd_addr  = IDX_W'(idx_r + IDX_W'(1));
    unique case (state_r)
      fct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = (in_cmd == fct_pkg::CMD_NEXT) ? cursor_r[IDX_W-1:0] : '0;
        // Empty table: append the first key right away
        if (in_fire && in_cmd == fct_pkg::CMD_COUNT && distinct_r == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = {COUNT_ONE, key_in_w};
        end
      end
      fct_pkg::ST_SCAN: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = {sat_cnt, key_r};
        end else if (last && !full) begin
          wr_en = 1'b1;
        end
      end
      fct_pkg::ST_READ: begin
      end
      fct_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers: state, table fill, read cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fct_pkg::ST_IDLE;
      distinct_r <= '0;
      cursor_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_cmd == fct_pkg::CMD_COUNT && distinct_r == '0) begin
        distinct_r <= CNT_W'(1);
      end
      if (in_fire && in_cmd == fct_pkg::CMD_REWIND) begin
        cursor_r <= '0;
      end
      if (state_r == fct_pkg::ST_SCAN && !hit && last && !full) begin
        distinct_r <= distinct_r + CNT_W'(1);
      end
      if (state_r == fct_pkg::ST_READ) begin
        cursor_r <= cursor_r + CNT_W'(1);
      end
    end
  end

  // Command latch, scan index and pending result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= in_cmd;
      key_r      <= key_in_w;
      idx_r      <= '0;
      res_key_r  <= '0;
      // Empty table: the first key lands with a count of one
      res_occ_r  <= (in_cmd == fct_pkg::CMD_COUNT && distinct_r == '0) ? COUNT_ONE : '0;
      res_stat_r <= (in_cmd == fct_pkg::CMD_NEXT && cursor_r >= distinct_r) ?
                    fct_pkg::STAT_PAST_END : fct_pkg::STAT_OK;
    end else if (state_r == fct_pkg::ST_SCAN) begin
      priority if (hit) begin
        res_occ_r <= sat_cnt;
      end else if (last) begin
        if (full) begin
          res_stat_r <= fct_pkg::STAT_FULL;
        end else begin
          res_occ_r <= COUNT_ONE;
        end
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end else if (state_r == fct_pkg::ST_READ && cmd_r == fct_pkg::CMD_NEXT) begin
      res_occ_r <= rd_cnt;
      res_key_r <= rd_key;
    end
  end

  // Widen or trim the result to the port widths
  assign occ_ext   = 64'(res_occ_r);
  assign key_ext   = 64'(res_key_r);
  assign total_ext = 16'(distinct_r);

  // Output register: load when the finished result can move out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == fct_pkg::ST_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fct_pkg::ST_RESP && out_free) begin
      out_occ_r   <= occ_ext[fct_pkg::OCC_W-1:0];
      out_key_r   <= key_ext[fct_pkg::KEY_PORT_W-1:0];
      out_total_r <= total_ext[fct_pkg::TOTAL_W-1:0];
      out_more_r  <= (cursor_r < distinct_r);
      out_stat_r  <= res_stat_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_occurrences    = out_occ_r;
  assign out_key_out        = out_key_r;
  assign out_distinct_total = out_total_r;
  assign out_more_left      = out_more_r;
  assign out_status         = out_stat_r;

endmodule

>>> verif/frequency_count_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_count_table_test
// Drives count, rewind, next and unused commands into the frequency count
// table with random idling on both channels. A behavioral copy of the table
// predicts each result beat, and a monitor checks every field of every beat.
// The table is filled once, so traffic runs first on a partly filled table
// and then on a full one.
// ----------------------------------------------------------------------------
module frequency_count_table_test;

  localparam int          ENTRIES      = 64;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int          IDLE_PCT     = 21;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES = 80;

  typedef struct {
    logic [31:0]      occ;
    logic [31:0]      key;
    logic [6:0]       total;
    logic             more;
    fct_pkg::status_t stat;
  } table_beat_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd          = fct_pkg::CMD_COUNT;
  logic [31:0] in_key_in       = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [31:0] out_occurrences;
  logic [31:0] out_key_out;
  logic [6:0]  out_distinct_total;
  logic        out_more_left;
  logic [1:0]  out_status;

  // Behavioral copy of the table
  logic [31:0] stored_keys   [ENTRIES];
  logic [31:0] stored_counts [ENTRIES];
  int unsigned key_total = 0;
  int unsigned read_pos  = 0;

  table_beat_t pending_results[$];
  int          mismatches  = 0;
  int          beats_sent  = 0;
  int          quiet_count = 0;
  logic        steady      = 1'b0;

  frequency_count_table uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_key_in          (in_key_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_occurrences    (out_occurrences),
    .out_key_out        (out_key_out),
    .out_distinct_total (out_distinct_total),
    .out_more_left      (out_more_left),
    .out_status         (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int find_key(logic [31:0] key);
    for (int i = 0; i < key_total; i++) begin
      if (stored_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one command to the table copy and return the beat it produces.
  // Count saturation sits at the top of a 32-bit count and is out of reach
  // of a run this short; the predictor still holds the count there.
  function automatic table_beat_t table_response(logic [1:0] cmd, logic [31:0] key);
    table_beat_t r;
    int          slot;
    r.occ  = '0;
    r.key  = '0;
    r.stat = fct_pkg::STAT_OK;
    case (cmd)
      fct_pkg::CMD_COUNT: begin
        slot = find_key(key);
        if (slot >= 0) begin
          if (stored_counts[slot] != COUNT_MAX) stored_counts[slot]++;
          r.occ = stored_counts[slot];
        end else if (key_total >= ENTRIES) begin
          r.stat = fct_pkg::STAT_FULL;
        end else begin
          stored_keys[key_total]   = key;
          stored_counts[key_total] = 32'd1;
          key_total++;
          r.occ = 32'd1;
        end
      end
      fct_pkg::CMD_REWIND: begin
        read_pos = 0;
      end
      fct_pkg::CMD_NEXT: begin
        if (read_pos >= key_total) begin
          r.stat = fct_pkg::STAT_PAST_END;
        end else begin
          r.occ = stored_counts[read_pos];
          r.key = stored_keys[read_pos];
          read_pos++;
        end
      end
      default: ;
    endcase
    r.total = key_total[6:0];
    r.more  = (read_pos < key_total);
    return r;
  endfunction

  // Send one beat: outside steady stretches idle at random first, then hold valid until accepted.
  // Entered and left at a rising edge.
  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] key);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_key_in <= key;
    pending_results.push_back(table_response(cmd, key));
    beats_sent++;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Rewind and read every entry, then one read past the end
  task automatic walk_table();
    int unsigned reads;
    reads = key_total + 1;
    send_beat(fct_pkg::CMD_REWIND, $urandom);
    for (int i = 0; i < reads; i++) send_beat(fct_pkg::CMD_NEXT, $urandom);
  endtask

  task automatic count_fresh_key();
    logic [31:0] key;
    do key = $urandom; while (find_key(key) >= 0);
    send_beat(fct_pkg::CMD_COUNT, key);
  endtask

  // Mostly hits on stored keys and reads, with new keys, walks and noise
  task automatic run_mixed_traffic(input int beats);
    int stop_at;
    int pick;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 && key_total > 0)
        send_beat(fct_pkg::CMD_COUNT, stored_keys[$urandom_range(0, key_total - 1)]);
      else if (pick < 63)
        send_beat(fct_pkg::CMD_COUNT, $urandom);
      else if (pick < 64)
        walk_table();
      else if (pick < 70)
        send_beat(fct_pkg::CMD_REWIND, $urandom);
      else if (pick < 95)
        send_beat(fct_pkg::CMD_NEXT, $urandom);
      else
        send_beat(CMD_UNUSED, $urandom);
    end
  endtask

  // Empty table, extreme keys, reads before any rewind, append after end
  task automatic test_first_entries();
    send_beat(fct_pkg::CMD_NEXT, 32'h0);
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF);
    send_beat(fct_pkg::CMD_COUNT, 32'h0000_0000);
    send_beat(fct_pkg::CMD_COUNT, 32'hFFFF_FFFF);
    send_beat(fct_pkg::CMD_NEXT, 32'h5555_5555);
    send_beat(fct_pkg::CMD_COUNT, 32'h0000_0000);
    send_beat(fct_pkg::CMD_NEXT, 32'hAAAA_AAAA);
    send_beat(fct_pkg::CMD_NEXT, 32'h0);
    send_beat(fct_pkg::CMD_COUNT, 32'hA5A5_A5A5);
    send_beat(fct_pkg::CMD_NEXT, 32'h0);
    send_beat(fct_pkg::CMD_NEXT, 32'h0);
    send_beat(fct_pkg::CMD_COUNT, 32'h5555_5555);
    send_beat(fct_pkg::CMD_COUNT, 32'hAAAA_AAAA);
    send_beat(fct_pkg::CMD_COUNT, 32'hFFFF_FFFF);
    send_beat(fct_pkg::CMD_REWIND, 32'hFFFF_FFFF);
    send_beat(fct_pkg::CMD_NEXT, 32'hFFFF_FFFF);
    send_beat(CMD_UNUSED, 32'h0);
    send_beat(fct_pkg::CMD_REWIND, 32'h0);
    send_beat(fct_pkg::CMD_REWIND, 32'h0);
  endtask

  task automatic test_filling_traffic();
    steady = 1'b1;
    run_mixed_traffic(200);
    steady = 1'b0;
    run_mixed_traffic(600);
  endtask

  // Fill every free entry, offer new keys and a stored key to the full table, then walk it
  task automatic test_table_full();
    while (key_total < ENTRIES) count_fresh_key();
    count_fresh_key();
    send_beat(fct_pkg::CMD_COUNT, 32'hFFFF_FFFF);
    count_fresh_key();
    send_beat(fct_pkg::CMD_COUNT, stored_keys[ENTRIES - 1]);
    walk_table();
  endtask

  task automatic test_full_table_traffic();
    steady = 1'b1;
    run_mixed_traffic(300);
    steady = 1'b0;
    run_mixed_traffic(550);
  endtask

  // Stall the result channel at random, except in steady stretches
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Check each result beat against the oldest prediction
  always @(negedge clk) begin
    table_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: occurrences %h, status %h",
                   out_occurrences, out_status);
      end else begin
        want = pending_results.pop_front();
        compare_field("occurrences", want.occ, out_occurrences);
        compare_field("key_out", want.key, out_key_out);
        compare_field("distinct_total", 32'(want.total), 32'(out_distinct_total));
        compare_field("more_left", 32'(want.more), 32'(out_more_left));
        compare_field("status", 32'(want.stat), 32'(out_status));
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_entries();
    test_filling_traffic();
    test_table_full();
    test_full_table_traffic();
    in_valid <= 1'b0;
    // Drain outstanding results, then watch for stray beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> frequency_count_table.f
sv/fct_pkg.sv
sv/fct_ram.sv
sv/frequency_count_table.sv
verif/frequency_count_table_test.sv
